// ----- hw/rtl/thermt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor temperature package
// Shared types, register indexes, status codes and fixed-point constants.
// ----------------------------------------------------------------------------
package thermt_pkg;

  localparam int ADC_BITS_DEF = 12;

  typedef enum logic [2:0] {
    CFG_COEF_A      = 3'd0,
    CFG_COEF_B      = 3'd1,
    CFG_COEF_C      = 3'd2,
    CFG_COEF_D      = 3'd3,
    CFG_REF_OHMS    = 3'd4,
    CFG_SERIES_OHMS = 3'd5,
    CFG_SUPPLY_MV   = 3'd6,
    CFG_OFFSET_MV   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_UNDEF = 2'd2
  } status_t;

  localparam logic signed [31:0] COEF_A_RST = 32'sd230486224;
  localparam logic signed [31:0] COEF_B_RST = 32'sd20161656;
  localparam logic signed [31:0] COEF_C_RST = 32'sd240128;
  localparam logic signed [31:0] COEF_D_RST = -32'sd53002;
  localparam logic [19:0] REF_OHMS_RST    = 20'd1000;
  localparam logic [19:0] SERIES_OHMS_RST = 20'd989;
  localparam logic [12:0] SUPPLY_MV_RST   = 13'd3260;
  localparam logic [12:0] OFFSET_MV_RST   = 13'd200;

  // ln(2) in Q32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  // 100 * 2^36
  localparam logic [43:0] NUM_Q36 = 44'h640_0000_0000;
  localparam logic signed [17:0] KELVIN_CENTI = 18'sd27315;
  localparam logic signed [15:0] TEMP_MAX = 16'sh7fff;
  localparam logic signed [15:0] TEMP_MIN = -16'sh8000;

endpackage

// ----- hw/rtl/thermt_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor sample channel
// Valid/ready channel carrying one converter sample per item.
// ----------------------------------------------------------------------------
interface thermt_in_if import thermt_pkg::*; #(
  parameter int AdcBits = ADC_BITS_DEF
) ();
  logic               valid;
  logic               ready;
  logic [AdcBits-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

// ----- hw/rtl/thermt_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor result channel
// Valid/ready channel carrying temperature and status per item.
// ----------------------------------------------------------------------------
interface thermt_out_if import thermt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [15:0] temp_centi;
  status_t            status;

  modport source (output valid, output temp_centi, output status, input ready);
  modport sink   (input valid, input temp_centi, input status, output ready);
endinterface

// ----- hw/rtl/thermt_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface thermt_cfg_if import thermt_pkg::*; ();
  logic        valid;
  logic        ready;
  cfg_idx_t    index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/thermistor_temperature.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor temperature
// Converter sample to temperature in hundredths of a degree Celsius through
// divider resistance, log2 by repeated squaring and a cubic Steinhart-Hart fit.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  in_s    | in  | valid/ready | adc_code
//  out_m   | out | valid/ready | temp_centi, status
//  cfg_s   | in  | valid/ready | index, data (always ready)
//
//  50 register stages; one item per cycle while out_m.ready does not stall the pipe.
//  The 20 squaring stages of the log and the 16 quotient-bit stages set depth.
//  Each stage holds only while the stage after it is full and held, so bubbles
//  close up and new items enter while a result waits at the output.
//  Reset (synchronous, rst_n low) empties the pipe and loads default registers.
// ----------------------------------------------------------------------------
module thermistor_temperature import thermt_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  thermt_in_if.sink   in_s,
  thermt_out_if.source out_m,
  thermt_cfg_if.sink  cfg_s
);

  localparam int NW  = ADC_BITS + 15;     // divider node terms
  localparam int PW  = NW + 20;           // resistance numerator / denominator
  localparam int EW  = $clog2(PW);        // log integer part
  localparam int DW  = EW + 22;           // log difference
  localparam int RW  = DW + 33;           // difference times ln2
  localparam int LW  = DW - 3;            // natural log, Q16
  localparam int SW  = 43;                // polynomial accumulator
  localparam int HW  = SW + LW;           // polynomial product
  localparam int QW  = 58;                // division remainder

  localparam int S_NR   = 1;
  localparam int S_PQ   = 2;
  localparam int S_NORM = 3;
  localparam int S_SQ   = 4;
  localparam int S_DIF  = 24;
  localparam int S_LN   = 25;
  localparam int S_HOR  = 26;
  localparam int S_PREP = 32;
  localparam int S_DIV  = 33;
  localparam int S_FIN  = 49;
  localparam int NST    = 50;

  localparam logic [ADC_BITS-1:0] CODE_MAX = '1;
  localparam logic signed [RW-1:0] RND36 = RW'(64'h8_0000_0000);
  localparam logic signed [HW-1:0] RND16 = HW'(64'h8000);
  localparam logic signed [HW-1:0] SLIM  = HW'(64'h200_0000_0000);

  // configuration registers
  logic signed [31:0] coef_a_r, coef_b_r, coef_c_r, coef_d_r;
  logic [19:0] ref_ohms_r, series_ohms_r;
  logic [12:0] supply_mv_r, offset_mv_r;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r      <= COEF_A_RST;
      coef_b_r      <= COEF_B_RST;
      coef_c_r      <= COEF_C_RST;
      coef_d_r      <= COEF_D_RST;
      ref_ohms_r    <= REF_OHMS_RST;
      series_ohms_r <= SERIES_OHMS_RST;
      supply_mv_r   <= SUPPLY_MV_RST;
      offset_mv_r   <= OFFSET_MV_RST;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.index)
        CFG_COEF_A:      coef_a_r      <= cfg_s.data;
        CFG_COEF_B:      coef_b_r      <= cfg_s.data;
        CFG_COEF_C:      coef_c_r      <= cfg_s.data;
        CFG_COEF_D:      coef_d_r      <= cfg_s.data;
        CFG_REF_OHMS:    ref_ohms_r    <= cfg_s.data[19:0];
        CFG_SERIES_OHMS: series_ohms_r <= cfg_s.data[19:0];
        CFG_SUPPLY_MV:   supply_mv_r   <= cfg_s.data[12:0];
        CFG_OFFSET_MV:   offset_mv_r   <= cfg_s.data[12:0];
      endcase
    end
  end

  // pipeline control
  logic [NST-1:0] vld_r, en, vld_in;
  logic [NST-1:0] und_r, und_in;
  logic           und_nxt;

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || out_m.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_s.ready = en[0];
  assign vld_in = {vld_r[NST-2:0], in_s.valid};

  always_comb begin
    und_in       = {und_r[NST-2:0], 1'b0};
    und_in[S_PQ] = und_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) vld_r[i] <= vld_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (en[i]) und_r[i] <= und_in[i];
    end
  end

  // stage 0: sample
  logic [ADC_BITS-1:0] code_r;
  always_ff @(posedge clk) begin
    if (en[0]) code_r <= in_s.adc_code;
  end

  // stage 1: divider node n and supply headroom r = (sup - off) * (max - code)
  logic signed [NW-1:0] off_w, sup_w, diff_w, code_w, rest_w, max_w;
  logic signed [NW-1:0] n_nxt, r_nxt, n_r, r_r;

  always_comb begin
    off_w  = signed'(NW'(offset_mv_r));
    sup_w  = signed'(NW'(supply_mv_r));
    diff_w = sup_w - off_w;
    code_w = signed'(NW'(code_r));
    max_w  = signed'(NW'(CODE_MAX));
    rest_w = max_w - code_w;
    n_nxt  = off_w * max_w + code_w * diff_w;
    r_nxt  = diff_w * rest_w;
  end

  always_ff @(posedge clk) begin
    if (en[S_NR]) begin
      n_r <= n_nxt;
      r_r <= r_nxt;
    end
  end

  // stage 2: resistance ratio numerator and denominator
  logic signed [PW-1:0] p_nxt, q_nxt, p_r, q_r;

  always_comb begin
    p_nxt   = signed'(PW'(series_ohms_r)) * PW'(r_r);
    q_nxt   = PW'(n_r) * signed'(PW'(ref_ohms_r));
    und_nxt = (p_nxt <= 0) || (q_nxt <= 0);
  end

  always_ff @(posedge clk) begin
    if (en[S_PQ]) begin
      p_r <= p_nxt;
      q_r <= q_nxt;
    end
  end

  // stage 3: leading one and mantissa normalized to Q30
  logic [30:0]   mp_r [0:20];
  logic [30:0]   mq_r [0:20];
  logic [19:0]   fp_r [0:20];
  logic [19:0]   fq_r [0:20];
  logic [EW-1:0] ep_r [0:20];
  logic [EW-1:0] eq_r [0:20];
  logic [EW-1:0] ep_nxt, eq_nxt;
  logic [PW-1:0] np_w, nq_w;

  always_comb begin
    ep_nxt = '0;
    eq_nxt = '0;
    for (int i = 0; i < PW; i++) begin
      if (p_r[i]) ep_nxt = EW'(i);
      if (q_r[i]) eq_nxt = EW'(i);
    end
    np_w = PW'(p_r) << (EW'(PW - 1) - ep_nxt);
    nq_w = PW'(q_r) << (EW'(PW - 1) - eq_nxt);
  end

  always_ff @(posedge clk) begin
    if (en[S_NORM]) begin
      mp_r[0] <= np_w[PW-1 -: 31];
      mq_r[0] <= nq_w[PW-1 -: 31];
      fp_r[0] <= '0;
      fq_r[0] <= '0;
      ep_r[0] <= ep_nxt;
      eq_r[0] <= eq_nxt;
    end
  end

  // stages 4..23: one fraction bit of each log2 per squaring
  for (genvar k = 0; k < 20; k++) begin : g_sq
    logic [61:0] sp, sq;
    logic [30:0] mp_nxt, mq_nxt;
    logic [19:0] fp_nxt, fq_nxt;

    always_comb begin
      sp     = 62'(mp_r[k]) * 62'(mp_r[k]);
      sq     = 62'(mq_r[k]) * 62'(mq_r[k]);
      mp_nxt = sp[61] ? sp[61:31] : sp[60:30];
      mq_nxt = sq[61] ? sq[61:31] : sq[60:30];
      fp_nxt = fp_r[k] | (sp[61] ? (20'd1 << (19 - k)) : 20'd0);
      fq_nxt = fq_r[k] | (sq[61] ? (20'd1 << (19 - k)) : 20'd0);
    end

    always_ff @(posedge clk) begin
      if (en[S_SQ+k]) begin
        mp_r[k+1] <= mp_nxt;
        mq_r[k+1] <= mq_nxt;
        fp_r[k+1] <= fp_nxt;
        fq_r[k+1] <= fq_nxt;
        ep_r[k+1] <= ep_r[k];
        eq_r[k+1] <= eq_r[k];
      end
    end
  end

  // stage 24: log2 difference times ln2
  logic signed [DW-1:0] dif_w;
  logic signed [RW-1:0] pr_nxt, pr_r;

  always_comb begin
    dif_w  = signed'(DW'({ep_r[20], fp_r[20]})) - signed'(DW'({eq_r[20], fq_r[20]}));
    pr_nxt = RW'(dif_w) * signed'(RW'(LN2_Q32));
  end

  always_ff @(posedge clk) begin
    if (en[S_DIF]) pr_r <= pr_nxt;
  end

  // stage 25: round to Q16
  logic signed [RW-1:0] prr_w;
  logic signed [LW-1:0] ln_r;

  assign prr_w = pr_r + RND36;

  always_ff @(posedge clk) begin
    if (en[S_LN]) ln_r <= signed'(prr_w[RW-1:36]);
  end

  // stages 26..31: Horner steps, multiply then round, add and clamp
  logic signed [SW-1:0] s_r  [0:3];
  logic signed [LW-1:0] lh_r [0:3];
  logic signed [31:0]   hk_w [0:2];

  assign s_r[0]  = SW'(coef_d_r);
  assign lh_r[0] = ln_r;
  assign hk_w[0] = coef_c_r;
  assign hk_w[1] = coef_b_r;
  assign hk_w[2] = coef_a_r;

  for (genvar h = 0; h < 3; h++) begin : g_hor
    logic signed [HW-1:0] hp_nxt, hp_r, hs_w;
    logic signed [LW-1:0] lm_r;
    logic signed [SW-1:0] hc_w;

    always_comb begin
      hp_nxt = HW'(s_r[h]) * HW'(lh_r[h]);
      hs_w   = ((hp_r + RND16) >>> 16) + HW'(hk_w[h]);
      priority if (hs_w > SLIM) begin
        hc_w = SW'(SLIM);
      end else if (hs_w < -SLIM) begin
        hc_w = SW'(-SLIM);
      end else begin
        hc_w = SW'(hs_w);
      end
    end

    always_ff @(posedge clk) begin
      if (en[S_HOR+2*h]) begin
        hp_r <= hp_nxt;
        lm_r <= lh_r[h];
      end
      if (en[S_HOR+2*h+1]) begin
        s_r[h+1]  <= hc_w;
        lh_r[h+1] <= lm_r;
      end
    end
  end

  // stage 32: magnitude, rounding bias and quotient range check
  logic [SW-1:0] sneg_w;
  logic [41:0]   sa_nxt;
  logic [43:0]   dv_nxt;
  logic          neg_nxt, sat_nxt;
  logic [41:0]   sa_r  [0:16];
  logic [QW-1:0] rem_r [0:16];
  logic [15:0]   quo_r [0:16];
  logic          neg_r [0:16];
  logic          sat_r [0:16];

  always_comb begin
    neg_nxt = s_r[3][SW-1];
    sneg_w  = SW'(-s_r[3]);
    sa_nxt  = neg_nxt ? sneg_w[41:0] : s_r[3][41:0];
    dv_nxt  = NUM_Q36 + 44'(sa_nxt >> 1);
    sat_nxt = QW'(dv_nxt) >= QW'({sa_nxt, 16'd0});
  end

  always_ff @(posedge clk) begin
    if (en[S_PREP]) begin
      sa_r[0]  <= sa_nxt;
      rem_r[0] <= QW'(dv_nxt);
      quo_r[0] <= '0;
      neg_r[0] <= neg_nxt;
      sat_r[0] <= sat_nxt;
    end
  end

  // stages 33..48: restoring division, one quotient bit per stage
  for (genvar j = 0; j < 16; j++) begin : g_div
    logic [QW-1:0] trial;
    logic          fit;

    always_comb begin
      trial = QW'(sa_r[j]) << (15 - j);
      fit   = rem_r[j] >= trial;
    end

    always_ff @(posedge clk) begin
      if (en[S_DIV+j]) begin
        rem_r[j+1] <= fit ? rem_r[j] - trial : rem_r[j];
        quo_r[j+1] <= quo_r[j] | (fit ? (16'd1 << (15 - j)) : 16'd0);
        sa_r[j+1]  <= sa_r[j];
        neg_r[j+1] <= neg_r[j];
        sat_r[j+1] <= sat_r[j];
      end
    end
  end

  // stage 49: sign, Kelvin offset, undefined result and saturation
  logic signed [17:0] qs_w, t_w;
  logic signed [15:0] temp_nxt, temp_r;
  status_t            stat_nxt, stat_r;

  always_comb begin
    qs_w = signed'({2'b00, quo_r[16]});
    t_w  = (neg_r[16] ? -qs_w : qs_w) - KELVIN_CENTI;
    priority if (und_r[S_FIN-1]) begin
      temp_nxt = '0;
      stat_nxt = ST_UNDEF;
    end else if (sat_r[16]) begin
      temp_nxt = neg_r[16] ? TEMP_MIN : TEMP_MAX;
      stat_nxt = ST_SAT;
    end else if (t_w > 18'(TEMP_MAX)) begin
      temp_nxt = TEMP_MAX;
      stat_nxt = ST_SAT;
    end else if (t_w < 18'(TEMP_MIN)) begin
      temp_nxt = TEMP_MIN;
      stat_nxt = ST_SAT;
    end else begin
      temp_nxt = t_w[15:0];
      stat_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_FIN]) begin
      temp_r <= temp_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_m.valid      = vld_r[NST-1];
  assign out_m.temp_centi = temp_r;
  assign out_m.status     = stat_r;

endmodule

// ----- hw/rtl/thermt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor temperature checker
// Port-level checks on result codes, reset and flow control.
// ----------------------------------------------------------------------------
module thermt_checker import thermt_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] temp_centi,
  input logic [1:0]         status
);

  // undefined log reports zero
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == ST_UNDEF) |-> temp_centi == 16'sd0)
    else $error("undefined result with nonzero temperature");

  // saturated result sits at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == ST_SAT) |-> (temp_centi == TEMP_MAX || temp_centi == TEMP_MIN))
    else $error("saturated result off the rails");

  // an empty output stage means the pipe can take an item
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(temp_centi) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind thermistor_temperature thermt_checker u_thermt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_s.ready),
  .out_valid  (out_m.valid),
  .out_ready  (out_m.ready),
  .temp_centi (out_m.temp_centi),
  .status     (out_m.status)
);
